FILE: hdl/tgq_pkg.sv
// tgq_pkg: shared types, constants and helper functions of the tempo grid quantiser
package tgq_pkg;

  localparam int MARKER_W = 48;
  localparam int PHASE_W  = 32;
  localparam int OUT_W    = 48;
  localparam int INC_W    = 32;
  localparam int DIV_W    = 11;
  localparam int MODE_W   = 2;
  localparam int IDX_W    = 8;
  localparam int PLACE_W  = 10;
  localparam int MAX_DIV  = 1024;
  localparam int RESET_DIV = 4;
  localparam int CNT_W    = $clog2(MARKER_W + 1);

  typedef logic [MARKER_W-1:0] marker_t;
  typedef logic [PHASE_W-1:0]  phase_t;
  typedef logic [DIV_W-1:0]    div_t;
  typedef logic [INC_W-1:0]    inc_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JUMP_BAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_JUMP_DIV = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd3;

  localparam logic [IDX_W-1:0] REG_PHASE_INCREMENT   = 8'd0;
  localparam logic [IDX_W-1:0] REG_DIVISIONS_PER_BAR = 8'd1;

  localparam phase_t PHASE_HALF = phase_t'({1'b1, {(PHASE_W-1){1'b0}}});

  typedef enum logic [1:0] {
    OP_TICK,
    OP_JUMP_BAR,
    OP_JUMP_DIV,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t     op;
    marker_t note;
    div_t    grid;
    div_t    offset;
  } item_t;

  // align the Q0.32 step to the phase format
  function automatic phase_t aligned_step(input inc_t inc);
    logic [PHASE_W+INC_W-1:0] wide;
    wide = {inc, {PHASE_W{1'b0}}};
    aligned_step = phase_t'(wide >> INC_W);
  endfunction

  function automatic div_t eff_divisions(input div_t d);
    if (d == div_t'(0)) begin
      eff_divisions = div_t'(1);
    end else if (d > div_t'(MAX_DIV)) begin
      eff_divisions = div_t'(MAX_DIV);
    end else begin
      eff_divisions = d;
    end
  endfunction

endpackage

FILE: hdl/tgq_front.sv
// tgq_front: accepts requests, classifies the mode and queues them for the back end
module tgq_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgq_pkg::MODE_W-1:0]   mode,
  input  logic [47:0]                  note_marker,
  input  logic [tgq_pkg::DIV_W-1:0]    grid_multiple,
  input  logic [tgq_pkg::DIV_W-1:0]    slot_offset,
  output logic                         q_valid,
  input  logic                         q_pop,
  output tgq_pkg::item_t               q_item
);

  tgq_pkg::item_t entries [2];
  tgq_pkg::item_t item_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    item_in.note   = tgq_pkg::marker_t'(note_marker);
    item_in.offset = slot_offset;
    item_in.grid   = (grid_multiple == tgq_pkg::div_t'(0)) ? tgq_pkg::div_t'(1) : grid_multiple;
    case (mode)
      tgq_pkg::MODE_TICK:     item_in.op = tgq_pkg::OP_TICK;
      tgq_pkg::MODE_JUMP_BAR: item_in.op = tgq_pkg::OP_JUMP_BAR;
      tgq_pkg::MODE_JUMP_DIV: item_in.op = tgq_pkg::OP_JUMP_DIV;
      default:                item_in.op = tgq_pkg::OP_QUERY;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/tgq_divider.sv
// tgq_divider: bit-serial restoring divider that returns the remainder
module tgq_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tgq_pkg::marker_t  dividend,
  input  tgq_pkg::div_t     divisor,
  output logic              busy,
  output tgq_pkg::div_t     remainder
);

  tgq_pkg::marker_t            num;
  tgq_pkg::div_t               den;
  tgq_pkg::cnt_t               cnt;
  logic [tgq_pkg::DIV_W:0]     trial;
  logic [tgq_pkg::DIV_W:0]     diff;

  assign trial = {remainder, num[tgq_pkg::MARKER_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= tgq_pkg::cnt_t'(0);
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= tgq_pkg::cnt_t'(tgq_pkg::MARKER_W);
    end else if (busy) begin
      cnt <= cnt - tgq_pkg::cnt_t'(1);
      if (cnt == tgq_pkg::cnt_t'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num       <= dividend;
      den       <= divisor;
      remainder <= tgq_pkg::div_t'(0);
    end else if (busy) begin
      num <= {num[tgq_pkg::MARKER_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        remainder <= diff[tgq_pkg::DIV_W-1:0];
      end else begin
        remainder <= trial[tgq_pkg::DIV_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/tgq_back.sv
// tgq_back: grid clock state, configuration registers, remainder sequencing and result register
module tgq_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [tgq_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tgq_pkg::INC_W-1:0]    cfg_data,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  tgq_pkg::item_t               q_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgq_pkg::OUT_W-1:0]    marker,
  output logic [tgq_pkg::OUT_W-1:0]    bar_start,
  output logic [tgq_pkg::PLACE_W-1:0]  place_in_bar,
  output logic                         note_due,
  output logic [tgq_pkg::OUT_W-1:0]    next_note_slot,
  output logic [tgq_pkg::OUT_W-1:0]    next_grid_slot
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  tgq_pkg::inc_t      phase_increment;
  tgq_pkg::div_t      divisions_per_bar;
  tgq_pkg::phase_t    phase_fraction;
  tgq_pkg::phase_t    phase_fraction_next;
  tgq_pkg::marker_t   grid_marker;
  tgq_pkg::marker_t   grid_marker_next;
  tgq_pkg::marker_t   next_bar_mark;
  tgq_pkg::marker_t   next_bar_mark_next;
  tgq_pkg::item_t     cur;
  tgq_pkg::div_t      div_eff;
  tgq_pkg::marker_t   div_ext;
  logic [tgq_pkg::PHASE_W:0] sum;
  logic               advance;
  tgq_pkg::marker_t   base;
  tgq_pkg::marker_t   bar;
  tgq_pkg::marker_t   grid_slot;
  logic               div_start;
  logic               bar_busy;
  logic               grid_busy;
  tgq_pkg::div_t      bar_rem;
  tgq_pkg::div_t      grid_rem;
  logic               load;

  assign div_eff = tgq_pkg::eff_divisions(divisions_per_bar);
  assign div_ext = tgq_pkg::marker_t'(div_eff);
  assign sum     = {1'b0, phase_fraction} + {1'b0, tgq_pkg::aligned_step(phase_increment)};
  assign base    = (phase_fraction < tgq_pkg::PHASE_HALF) ? grid_marker
                                                          : grid_marker + tgq_pkg::marker_t'(1);
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign div_start = (state == S_START);
  assign load      = (state == S_EMIT) && (!out_valid || !out_stall);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment   <= tgq_pkg::inc_t'(0);
      divisions_per_bar <= tgq_pkg::div_t'(tgq_pkg::RESET_DIV);
    end else if (cfg_valid) begin
      case (cfg_index)
        tgq_pkg::REG_PHASE_INCREMENT:   phase_increment   <= cfg_data;
        tgq_pkg::REG_DIVISIONS_PER_BAR: divisions_per_bar <= cfg_data[tgq_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // grid clock update
  always_comb begin
    phase_fraction_next = phase_fraction;
    grid_marker_next    = grid_marker;
    next_bar_mark_next  = next_bar_mark;
    advance             = 1'b0;
    case (q_item.op)
      tgq_pkg::OP_TICK: begin
        phase_fraction_next = sum[tgq_pkg::PHASE_W-1:0];
        advance             = sum[tgq_pkg::PHASE_W];
      end
      tgq_pkg::OP_JUMP_BAR: begin
        phase_fraction_next = tgq_pkg::phase_t'(0);
        grid_marker_next    = next_bar_mark;
        next_bar_mark_next  = next_bar_mark + div_ext;
      end
      tgq_pkg::OP_JUMP_DIV: begin
        phase_fraction_next = tgq_pkg::phase_t'(0);
        advance             = 1'b1;
      end
      default: ;
    endcase
    if (advance) begin
      grid_marker_next = grid_marker + tgq_pkg::marker_t'(1);
      if (grid_marker == next_bar_mark) begin
        next_bar_mark_next = next_bar_mark + div_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_fraction <= tgq_pkg::phase_t'(0);
      grid_marker    <= tgq_pkg::marker_t'(0);
      next_bar_mark  <= tgq_pkg::marker_t'(tgq_pkg::RESET_DIV);
    end else if (q_pop) begin
      phase_fraction <= phase_fraction_next;
      grid_marker    <= grid_marker_next;
      next_bar_mark  <= next_bar_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  tgq_divider u_bar_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (grid_marker),
    .divisor   (div_eff),
    .busy      (bar_busy),
    .remainder (bar_rem)
  );

  tgq_divider u_grid_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (base),
    .divisor   (cur.grid),
    .busy      (grid_busy),
    .remainder (grid_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_valid) state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (!bar_busy && !grid_busy) state_next = S_EMIT;
      S_EMIT:  if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register
  assign bar       = grid_marker - tgq_pkg::marker_t'(bar_rem);
  assign grid_slot = base + tgq_pkg::marker_t'(cur.grid) + tgq_pkg::marker_t'(cur.offset)
                     - tgq_pkg::marker_t'(grid_rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      marker         <= tgq_pkg::OUT_W'(grid_marker);
      bar_start      <= tgq_pkg::OUT_W'(bar);
      place_in_bar   <= bar_rem[tgq_pkg::PLACE_W-1:0];
      note_due       <= (cur.note <= grid_marker);
      next_note_slot <= tgq_pkg::OUT_W'(base + tgq_pkg::marker_t'(1));
      next_grid_slot <= tgq_pkg::OUT_W'(grid_slot);
    end
  end

endmodule

FILE: hdl/tempo_grid_quantiser.sv
// tempo_grid_quantiser: top level of the tempo-locked grid clock
// Each request (tick, jump to next bar, jump to next division or query) yields one
// result with the marker, bar start, place in bar, note due flag and the next fine
// and coarse note slots; all but a query first update the phase accumulator and
// division marker. The clock state is updated in the cycle a request leaves the queue.
// From there it reaches the result register by starting the two bit-serial remainder
// units (marker mod divisions and slot base mod grid multiple), taking their 48 steps,
// seeing them finish and loading the result. The next request leaves the queue in the
// cycle after the load, so the back end takes one request at a time; a stalled result
// holds the back end until it is taken.
// A two-entry input queue and the result register let both sides stall on their own.
// Configuration writes are always ready and are to be made while no request is pending.
module tempo_grid_quantiser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tgq_pkg::MODE_W-1:0]   mode,
  input  logic [47:0]                  note_marker,
  input  logic [tgq_pkg::DIV_W-1:0]    grid_multiple,
  input  logic [tgq_pkg::DIV_W-1:0]    slot_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tgq_pkg::OUT_W-1:0]    marker,
  output logic [tgq_pkg::OUT_W-1:0]    bar_start,
  output logic [tgq_pkg::PLACE_W-1:0]  place_in_bar,
  output logic                         note_due,
  output logic [tgq_pkg::OUT_W-1:0]    next_note_slot,
  output logic [tgq_pkg::OUT_W-1:0]    next_grid_slot,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tgq_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tgq_pkg::INC_W-1:0]    cfg_data
);

  logic           q_valid;
  logic           q_pop;
  tgq_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  tgq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .note_marker   (note_marker),
    .grid_multiple (grid_multiple),
    .slot_offset   (slot_offset),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item)
  );

  tgq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .marker         (marker),
    .bar_start      (bar_start),
    .place_in_bar   (place_in_bar),
    .note_due       (note_due),
    .next_note_slot (next_note_slot),
    .next_grid_slot (next_grid_slot)
  );

endmodule

FILE: tb/sv/tempo_grid_quantiser_tb.sv
// tempo_grid_quantiser_tb: self-checking testbench for the tempo grid quantiser
module tempo_grid_quantiser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgq_pkg::*;

  localparam int IDLE_LIMIT      = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_SHOWN       = 10;
  localparam int TAIL_CYCLES     = 60;

  typedef struct {
    marker_t            marker;
    marker_t            bar_start;
    logic [PLACE_W-1:0] place;
    logic               due;
    marker_t            note_slot;
    marker_t            grid_slot;
  } grid_result_t;

  class grid_scoreboard;
    phase_t       phase_acc;
    marker_t      grid_mark;
    marker_t      bar_mark;
    inc_t         step;
    div_t         div_reg;
    grid_result_t expected_q[$];
    int           mismatches;
    int           results_seen;
    int           wraps;
    int           op_seen[4];

    function new();
      phase_acc = '0;
      grid_mark = '0;
      bar_mark = marker_t'(RESET_DIV);
      step = '0;
      div_reg = div_t'(RESET_DIV);
    endfunction

    function logic [63:0] divs_in_use();
      if (div_reg == '0) return 64'd1;
      if (div_reg > div_t'(MAX_DIV)) return 64'(MAX_DIV);
      return 64'(div_reg);
    endfunction

    function void advance_marker();
      marker_t prior;
      prior = grid_mark;
      grid_mark = grid_mark + 1'b1;
      if (prior == bar_mark) bar_mark = bar_mark + marker_t'(divs_in_use());
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, inc_t data);
      case (idx)
        REG_PHASE_INCREMENT: step = data;
        REG_DIVISIONS_PER_BAR: div_reg = data[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [MODE_W-1:0] m, marker_t note, div_t gm, div_t off);
      logic [PHASE_W:0] sum;
      logic [63:0]      d;
      logic [63:0]      g;
      logic [63:0]      bar;
      logic [63:0]      base;
      logic [63:0]      gs;
      logic [63:0]      pb;
      grid_result_t     r;
      d = divs_in_use();
      op_seen[m]++;
      case (op_t'(m))
        OP_TICK: begin
          sum = {1'b0, phase_acc} + {1'b0, step};
          phase_acc = sum[PHASE_W-1:0];
          if (sum[PHASE_W]) begin
            wraps++;
            advance_marker();
          end
        end
        OP_JUMP_BAR: begin
          phase_acc = '0;
          grid_mark = bar_mark;
          bar_mark = grid_mark + marker_t'(d);
        end
        OP_JUMP_DIV: begin
          phase_acc = '0;
          advance_marker();
        end
        default: ;
      endcase
      g = (gm == '0) ? 64'd1 : 64'(gm);
      bar = 64'(grid_mark) - 64'(grid_mark) % d;
      pb = 64'(grid_mark) - bar;
      if (phase_acc < PHASE_HALF) begin
        base = 64'(grid_mark);
      end else begin
        base = 64'(marker_t'(grid_mark + 1'b1));
      end
      gs = base + g + 64'(off) - base % g;
      r.marker = grid_mark;
      r.bar_start = bar[MARKER_W-1:0];
      r.place = pb[PLACE_W-1:0];
      r.due = (note <= grid_mark);
      r.note_slot = marker_t'(base + 64'd1);
      r.grid_slot = gs[MARKER_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("mismatch on %s in result %0d: expected 0x%0h, got 0x%0h",
                   name, results_seen, want, got);
      end
    endfunction

    function void check_result(grid_result_t got);
      grid_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result %0d arrived with no request pending", results_seen);
        return;
      end
      want = expected_q.pop_front();
      compare_field("marker", want.marker, got.marker);
      compare_field("bar_start", want.bar_start, got.bar_start);
      compare_field("place_in_bar", want.place, got.place);
      compare_field("note_due", want.due, got.due);
      compare_field("next_note_slot", want.note_slot, got.note_slot);
      compare_field("next_grid_slot", want.grid_slot, got.grid_slot);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [MODE_W-1:0]   mode = '0;
  logic [47:0]         note_marker = '0;
  logic [DIV_W-1:0]    grid_multiple = '0;
  logic [DIV_W-1:0]    slot_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OUT_W-1:0]    marker;
  logic [OUT_W-1:0]    bar_start;
  logic [PLACE_W-1:0]  place_in_bar;
  logic                note_due;
  logic [OUT_W-1:0]    next_note_slot;
  logic [OUT_W-1:0]    next_grid_slot;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [INC_W-1:0]    cfg_data = '0;

  grid_scoreboard sb = new();
  grid_result_t   seen_result;
  bit             moved;
  bit             gaps_on = 1'b1;
  bit             stall_enable = 1'b1;
  int             idle_cycles;
  int             stall_hold;
  int             settings;

  tempo_grid_quantiser dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .note_marker    (note_marker),
    .grid_multiple  (grid_multiple),
    .slot_offset    (slot_offset),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .marker         (marker),
    .bar_start      (bar_start),
    .place_in_bar   (place_in_bar),
    .note_due       (note_due),
    .next_note_slot (next_note_slot),
    .next_grid_slot (next_grid_slot),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic div_t pick_div();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return div_t'($urandom_range(0, 16));
    if (r < 90) return div_t'($urandom_range(0, MAX_DIV));
    return div_t'($urandom_range(0, 2047));
  endfunction

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        sb.note_request(mode, note_marker, grid_multiple, slot_offset);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        seen_result.marker = marker;
        seen_result.bar_start = bar_start;
        seen_result.place = place_in_bar;
        seen_result.due = note_due;
        seen_result.note_slot = next_note_slot;
        seen_result.grid_slot = next_grid_slot;
        sb.check_result(seen_result);
        moved = 1'b1;
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.expected_q.size());
        $display("tempo_grid_quantiser test failed");
        $finish;
      end
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (stall_enable && out_stall !== 1'b1 && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_hold = pick_gap();
    end else begin
      out_stall <= 1'b0;
      stall_hold = $urandom_range(0, 6);
    end
  end

  task automatic send_request(logic [MODE_W-1:0] m, marker_t note, div_t gm, div_t off);
    int gap;
    bit drain;
    in_valid <= 1'b1;
    mode <= m;
    note_marker <= note;
    grid_multiple <= gm;
    slot_offset <= off;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = gaps_on ? pick_gap() : 0;
    drain = ($urandom_range(0, 79) == 0);
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      while (drain && sb.expected_q.size() != 0) @(posedge clk);
    end
  endtask

  task automatic random_request();
    logic [MODE_W-1:0] m;
    marker_t           note;
    int                r;
    r = $urandom_range(0, 99);
    if (r < 50) m = MODE_TICK;
    else if (r < 62) m = MODE_JUMP_BAR;
    else if (r < 80) m = MODE_JUMP_DIV;
    else m = MODE_QUERY;
    case ($urandom_range(0, 9))
      0: note = marker_t'({$urandom(), $urandom()});
      1: note = '0;
      2: note = '1;
      // around the current marker so the due flag goes both ways
      default: note = sb.grid_mark + marker_t'($urandom_range(0, 6)) - marker_t'(3);
    endcase
    send_request(m, note, pick_div(), pick_div());
  endtask

  // wait for the next edge first so a request taken at the last edge is already counted
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_reg(logic [IDX_W-1:0] idx, inc_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic settle_config(inc_t inc, div_t divs);
    wait_drained();
    // junk in the upper data bits of the divisions write
    load_reg(REG_DIVISIONS_PER_BAR, ($urandom() & 32'hFFFF_F800) | inc_t'(divs));
    load_reg(REG_PHASE_INCREMENT, inc);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    inc_t inc;
    div_t divs;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings, then hand-picked walk through bars and divisions
    send_request(MODE_QUERY, '0, '0, '0);
    send_request(MODE_QUERY, '1, div_t'(MAX_DIV), div_t'(MAX_DIV));
    send_request(MODE_TICK, 48'h8000_0000_0000, '1, '1);
    settle_config(32'hFFFF_FFFF, div_t'(3));
    send_request(MODE_TICK, 48'd1, div_t'(1), '0);
    send_request(MODE_TICK, 48'd1, div_t'(2), div_t'(5));
    send_request(MODE_JUMP_DIV, 48'd2, div_t'(3), '0);
    send_request(MODE_JUMP_DIV, 48'd2, div_t'(3), div_t'(1));
    send_request(MODE_JUMP_DIV, 48'd4, div_t'(4), '0);
    send_request(MODE_JUMP_DIV, 48'd5, '0, div_t'(7));
    send_request(MODE_JUMP_BAR, 48'd7, div_t'(5), '0);
    send_request(MODE_QUERY, 48'd8, div_t'(6), div_t'(3));
    // zero divisions, bar mark keeps its old spacing until the next update
    settle_config(32'h8000_0000, '0);
    send_request(MODE_JUMP_BAR, 48'd10, div_t'(9), div_t'(2));
    send_request(MODE_TICK, 48'd11, div_t'(8), '0);
    send_request(MODE_TICK, 48'd11, div_t'(2047), div_t'(1024));
    send_request(MODE_JUMP_DIV, 48'd12, div_t'(2), div_t'(2047));
    // unknown register must be ignored
    wait_drained();
    load_reg(IDX_W'($urandom_range(2, 255)), $urandom());
    settle_config(32'h0000_0001, div_t'(2047));
    send_request(MODE_JUMP_BAR, '0, div_t'(MAX_DIV), '0);
    send_request(MODE_JUMP_BAR, '1, div_t'(1023), div_t'(1023));
    send_request(MODE_QUERY, '1, div_t'(MAX_DIV), '0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin inc = 32'h8000_0000; divs = div_t'(4); end
        1: begin inc = 32'hFFFF_FFFF; divs = div_t'(1); end
        2: begin inc = 32'h0000_0000; divs = '0; end
        3: begin inc = 32'h4000_0000; divs = div_t'(MAX_DIV); end
        4: begin inc = $urandom(); divs = div_t'(2047); end
        5: begin inc = 32'h0100_0000; divs = div_t'(3); end
        6: begin inc = $urandom(); divs = div_t'($urandom_range(1, MAX_DIV)); end
        default: begin inc = $urandom(); divs = div_t'(7); end
      endcase
      settle_config(inc, divs);
      gaps_on = (p % 3 != 1);
      stall_enable = (p % 4 != 2);
      repeat (ITEMS_PER_PHASE) random_request();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d ticks (%0d phase wraps), %0d bar jumps, %0d division jumps, %0d queries",
             sb.op_seen[MODE_TICK], sb.wraps, sb.op_seen[MODE_JUMP_BAR],
             sb.op_seen[MODE_JUMP_DIV], sb.op_seen[MODE_QUERY]);
    $display("across %0d register settings: %0d results checked, %0d mismatches",
             settings, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tempo_grid_quantiser test passed");
    end else begin
      $display("tempo_grid_quantiser test failed");
    end
    $finish;
  end

endmodule
